// ----- rtl/alist_pkg.sv -----
// ----------------------------------------------------------------------------
// alist_pkg: shared types and codes of the array list engine
// Request kind type and its codes, used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package alist_pkg;

	localparam int KIND_W = 2;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_INSERT = 2'd0;
	localparam kind_t KIND_DELETE = 2'd1;
	localparam kind_t KIND_GET    = 2'd2;
	localparam kind_t KIND_LOCATE = 2'd3;

endpackage

// ----- rtl/alist_if.sv -----
// ----------------------------------------------------------------------------
// alist_if: channel interfaces of the array list engine
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface alist_req_if #(
	parameter int POS_W  = 7,
	parameter int ELEM_W = 32
);
	logic                      valid;
	logic                      ready;
	alist_pkg::kind_t          kind;
	logic        [POS_W-1:0]   position;
	logic signed [ELEM_W-1:0]  value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface alist_res_if #(
	parameter int ELEM_W = 32,
	parameter int IDX_W  = 6,
	parameter int CNT_W  = 7
);
	logic                      valid;
	logic                      ready;
	logic                      ok;
	logic signed [ELEM_W-1:0]  elem_value;
	logic        [IDX_W-1:0]   found_index;
	logic        [CNT_W-1:0]   count;
	logic                      empty_res;
	logic                      full_res;

	modport source (output valid, ok, elem_value, found_index, count, empty_res, full_res,
		input ready);
	modport sink   (input valid, ok, elem_value, found_index, count, empty_res, full_res,
		output ready);
endinterface

interface alist_cfg_if #(
	parameter int CNT_W = 7
);
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/alist_store.sv -----
// ----------------------------------------------------------------------------
// alist_store: entry store of the array list engine
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module alist_store #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [ELEM_WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [ELEM_WIDTH-1:0]         rdata
);

	logic [ELEM_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old word when the same address is written
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/array_list_engine.sv -----
// ----------------------------------------------------------------------------
// array_list_engine: ordered list of signed words in a fixed store
// Usage: requests arrive on req (kind, position, value), one item per request;
// each yields exactly one result item on res (ok, elem_value, found_index,
// count, empty_res, full_res). cfg writes the capacity register; it is always
// ready. Write it only while the block is idle; the block does not check this.
// One request is worked at a time: req.ready is high only while the sequencer
// is idle, so the next item waits until the current result is registered.
// Insert and delete walk the store one entry per cycle through its single
// read and single write port; an append and a delete of the last entry skip
// the walk, and locate reads the entries in turn up to the first match.
// The result sits in an output register: a new request is taken while it
// waits; if the receiver still stalls when the next result is done, the
// sequencer holds in its final state until the register frees.
// Reset clears the count, the output valid and the sequencer and sets the
// capacity to the store depth; the store itself is not cleared, since only
// positions below the count are ever read.
// ----------------------------------------------------------------------------
module array_list_engine #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	alist_req_if.sink   req,
	alist_res_if.source res,
	alist_cfg_if.sink   cfg
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_PUT  = 3'd2;
	localparam logic [2:0] S_DEL  = 3'd3;
	localparam logic [2:0] S_GET  = 3'd4;
	localparam logic [2:0] S_GETD = 3'd5;
	localparam logic [2:0] S_LOC  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cap_q;
	logic [CNT_W-1:0]      pos_q;
	logic [ELEM_WIDTH-1:0] val_q;
	logic [IDX_W-1:0]      r_q;      // next store address to read
	logic [IDX_W-1:0]      wa_q;     // address tied to the read in flight
	logic                  iss_q;    // reads still to issue
	logic                  rd_pend_q;
	logic                  ok_q;
	logic [ELEM_WIDTH-1:0] elem_q;
	logic [IDX_W-1:0]      found_q;

	logic                  out_valid_q;
	logic                  res_ok_q;
	logic [ELEM_WIDTH-1:0] res_elem_q;
	logic [IDX_W-1:0]      res_found_q;
	logic [CNT_W-1:0]      res_cnt_q;
	logic                  res_empty_q;
	logic                  res_full_q;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [ELEM_WIDTH-1:0] wdata;
	logic [IDX_W-1:0]      raddr;
	logic [ELEM_WIDTH-1:0] rdata;
	logic [CNT_W-1:0]      cap_eff;
	logic [CNT_W-1:0]      cnt_m1;
	logic                  match;
	logic                  out_free;

	alist_store #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// capacity above the store depth saturates at the depth
	assign cap_eff  = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign cnt_m1   = cnt_q - CNT_W'(1);
	// the one compare unit: store word against the search value
	assign match    = (rdata == val_q);
	assign out_free = !out_valid_q || res.ready;

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign res.valid       = out_valid_q;
	assign res.ok          = res_ok_q;
	assign res.elem_value  = res_elem_q;
	assign res.found_index = res_found_q;
	assign res.count       = res_cnt_q;
	assign res.empty_res   = res_empty_q;
	assign res.full_res    = res_full_q;

	// store port steering: moves write back the word read in the cycle before
	always_comb begin
		we    = 1'b0;
		waddr = wa_q;
		wdata = rdata;
		raddr = r_q;
		unique case (state_q)
			S_INS, S_DEL: begin
				we = rd_pend_q;
			end
			S_PUT: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
				wdata = val_q;
			end
			S_GET: begin
				raddr = pos_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cap_q       <= CNT_W'(DEPTH);
			pos_q       <= '0;
			val_q       <= '0;
			r_q         <= '0;
			wa_q        <= '0;
			iss_q       <= 1'b0;
			rd_pend_q   <= 1'b0;
			ok_q        <= 1'b0;
			elem_q      <= '0;
			found_q     <= '0;
			out_valid_q <= 1'b0;
			res_ok_q    <= 1'b0;
			res_elem_q  <= '0;
			res_found_q <= '0;
			res_cnt_q   <= '0;
			res_empty_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			// load a finished result, else drop the one the receiver took
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						pos_q     <= req.position;
						val_q     <= req.value;
						elem_q    <= '0;
						found_q   <= '0;
						rd_pend_q <= 1'b0;
						unique case (req.kind)
							alist_pkg::KIND_INSERT: begin
								ok_q <= 1'b0;
								if (req.position <= cnt_q && cnt_q < cap_eff) begin
									if (req.position == cnt_q) begin
										state_q <= S_PUT;
									end else begin
										// shift up from the last entry down to position
										r_q     <= cnt_m1[IDX_W-1:0];
										iss_q   <= 1'b1;
										state_q <= S_INS;
									end
								end else begin
									state_q <= S_FIN;
								end
							end
							alist_pkg::KIND_DELETE: begin
								if (req.position < cnt_q) begin
									if (req.position == cnt_m1) begin
										cnt_q   <= cnt_m1;
										ok_q    <= 1'b1;
										state_q <= S_FIN;
									end else begin
										// shift down from position + 1 to the last entry
										ok_q    <= 1'b0;
										r_q     <= IDX_W'(req.position + CNT_W'(1));
										iss_q   <= 1'b1;
										state_q <= S_DEL;
									end
								end else begin
									ok_q    <= 1'b0;
									state_q <= S_FIN;
								end
							end
							alist_pkg::KIND_GET: begin
								ok_q <= 1'b0;
								if (req.position < cnt_q) begin
									state_q <= S_GET;
								end else begin
									state_q <= S_FIN;
								end
							end
							alist_pkg::KIND_LOCATE: begin
								ok_q <= 1'b0;
								if (cnt_q != '0) begin
									r_q     <= '0;
									iss_q   <= 1'b1;
									state_q <= S_LOC;
								end else begin
									state_q <= S_FIN;
								end
							end
						endcase
					end
				end
				S_INS: begin
					if (iss_q) begin
						rd_pend_q <= 1'b1;
						wa_q      <= r_q + IDX_W'(1);
						if (r_q == pos_q[IDX_W-1:0]) begin
							iss_q <= 1'b0;
						end else begin
							r_q <= r_q - IDX_W'(1);
						end
					end else begin
						// last move writes this cycle; the new value goes in next
						rd_pend_q <= 1'b0;
						state_q   <= S_PUT;
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					ok_q    <= 1'b1;
					state_q <= S_FIN;
				end
				S_DEL: begin
					if (iss_q) begin
						rd_pend_q <= 1'b1;
						wa_q      <= r_q - IDX_W'(1);
						if (r_q == cnt_m1[IDX_W-1:0]) begin
							iss_q <= 1'b0;
						end else begin
							r_q <= r_q + IDX_W'(1);
						end
					end else begin
						rd_pend_q <= 1'b0;
						cnt_q     <= cnt_m1;
						ok_q      <= 1'b1;
						state_q   <= S_FIN;
					end
				end
				S_GET: begin
					state_q <= S_GETD;
				end
				S_GETD: begin
					elem_q  <= rdata;
					ok_q    <= 1'b1;
					state_q <= S_FIN;
				end
				S_LOC: begin
					priority if (rd_pend_q && match) begin
						// first hit wins; drop the read still in flight
						ok_q      <= 1'b1;
						found_q   <= wa_q;
						rd_pend_q <= 1'b0;
						iss_q     <= 1'b0;
						state_q   <= S_FIN;
					end else if (iss_q) begin
						rd_pend_q <= 1'b1;
						wa_q      <= r_q;
						if (r_q == cnt_m1[IDX_W-1:0]) begin
							iss_q <= 1'b0;
						end else begin
							r_q <= r_q + IDX_W'(1);
						end
					end else begin
						rd_pend_q <= 1'b0;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						res_ok_q    <= ok_q;
						res_elem_q  <= elem_q;
						res_found_q <= found_q;
						res_cnt_q   <= cnt_q;
						res_empty_q <= (cnt_q == '0);
						res_full_q  <= (cnt_q >= cap_eff);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// count moves by one at most per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			(cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("entry count jumped by more than one");

	// an insert only completes below the effective capacity
	a_put_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> (cnt_q < cap_eff))
		else $error("insert completing at or above capacity");

	// locate compares only live entries
	a_loc_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOC && rd_pend_q) |-> (CNT_W'(wa_q) < cnt_q))
		else $error("locate compared an entry beyond the count");

	// an accepted request makes the block busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while a request is in progress");

endmodule
